[src/fnsb_pkg.sv]
// Shared types and constants for the failover node selector with backoff.
package fnsb_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_NODE_COUNT  = 2'd0;
  localparam logic [1:0] CFG_PAIRED_MASK = 2'd1;
  localparam logic [1:0] CFG_LOCAL_MASK  = 2'd2;

  // Request kinds carried on the input tuser
  localparam logic MODE_SELECT = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  // Backoff limits
  localparam logic [3:0] FAIL_CAP  = 4'd10;
  localparam logic [3:0] DELAY_LOG = 4'd9;    // 2^9 is the first power above the cap
  localparam logic [8:0] DELAY_CAP = 9'd300;

  // Node classes, lower wins
  localparam logic [1:0] CLASS_PAIRED_LOCAL = 2'd0;
  localparam logic [1:0] CLASS_PAIRED       = 2'd1;
  localparam logic [1:0] CLASS_OTHER        = 2'd2;
  localparam logic [1:0] CLASS_NONE         = 2'd3;

  localparam int unsigned RETRY_W = 33;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RPT_RD,
    ST_RPT_WR,
    ST_DONE
  } state_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // One node record as held in the node memory
  typedef struct packed {
    logic [3:0]         fail_cnt;
    logic [RETRY_W-1:0] retry;
  } node_rec_t;

endpackage

[src/failover_node_selector_backoff_unit.sv]
// Failover node selector: iterative pool scan and backoff bookkeeping.
//
// One request is handled at a time. A select request (tuser = 0) walks the
// pool one node per cycle through the node memory and a shared 34-bit
// add/subtract unit that checks each retry time against now. With
// n = min(node_count, NODES), it scans n nodes and a drain state, then
// loads the output register (an empty pool goes there at once). A report
// request (tuser = 1) reads the node record, then on a failure writes back
// the raised fail count and now + backoff formed in the same unit, or on a
// success writes a zero record and marks the node active; a node outside
// the pool goes straight to the result. The input is not ready while a
// request is being worked on; a finished result waits in the output
// register, and while an earlier result still sits there unread the block
// holds and stays not ready. Node records reset to zero through per-entry
// valid bits, so no clearing pass follows reset.
module failover_node_selector_backoff_unit #(
  parameter int unsigned NODES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // now[31:0], skip_mask[39:32], node_index[42:40],
                                     // succeeded[43], zero[47:44]
  input  logic [0:0]  s_axis_tuser,  // mode[0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // found[0], selected_index[3:1], active_valid[4],
                                     // active_slot[7:5]
);
  import fnsb_pkg::*;

  localparam int unsigned IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned CW = $clog2(NODES + 1);

  // configuration registers
  logic [3:0] node_count_q;
  logic [7:0] paired_mask_q, local_mask_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= '0;
      paired_mask_q <= '0;
      local_mask_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NODE_COUNT:  node_count_q  <= cfg_data_i[3:0];
        CFG_PAIRED_MASK: paired_mask_q <= cfg_data_i;
        CFG_LOCAL_MASK:  local_mask_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request fields
  logic        in_mode;
  logic [31:0] in_now;
  logic [7:0]  in_skip;
  logic [2:0]  in_idx;
  logic        in_ok;

  assign in_mode = s_axis_tuser[0];
  assign in_now  = s_axis_tdata[31:0];
  assign in_skip = s_axis_tdata[39:32];
  assign in_idx  = s_axis_tdata[42:40];
  assign in_ok   = s_axis_tdata[43];

  // control and request registers
  state_e        state_q, state_d;
  logic [31:0]   now_q, now_d;
  logic [7:0]    skip_q, skip_d;
  logic [2:0]    idx_q, idx_d;
  logic          ok_q, ok_d;
  logic [CW-1:0] eff_q, eff_d;
  logic [IW-1:0] scan_q, scan_d;
  logic          cmp_v_q, cmp_v_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;
  logic [1:0]    best_q, best_d;
  logic          found_q, found_d;
  logic [2:0]    sel_q, sel_d;
  logic          act_flag_q, act_flag_d;
  logic [2:0]    act_node_q, act_node_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_data_q, out_data_d;

  // node memory with reset-to-zero valid bits
  node_rec_t     mem [NODES];
  logic [NODES-1:0] vld_q;
  node_rec_t     rd_q;
  logic          rd_vld_q;
  node_rec_t     rd_rec;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  node_rec_t     mem_wdata;

  assign rd_rec = rd_vld_q ? rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[IW'(idx_q)] <= mem_wdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[IW'(idx_q)] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  // shared add/subtract unit: now +/- operand, 34 bits so the sign survives
  alu_op_e            alu_op;
  logic [RETRY_W-1:0] alu_b;
  logic [33:0]        alu_res;

  assign alu_res = (alu_op == ALU_SUB)
                 ? ({2'b00, now_q} + ~{1'b0, alu_b} + 34'd1)
                 : ({2'b00, now_q} + {1'b0, alu_b});

  // compare stage: class of the node whose record just came out of memory
  logic       cmp_low8;
  logic [2:0] cmp_lo3;
  logic       cmp_skip, cmp_paired, cmp_local, cmp_due, cmp_elig;
  logic [1:0] cmp_class;

  assign cmp_low8   = (32'(cmp_idx_q) < 32'd8);
  assign cmp_lo3    = 3'(cmp_idx_q);
  assign cmp_skip   = cmp_low8 && skip_q[cmp_lo3];
  assign cmp_paired = cmp_low8 && paired_mask_q[cmp_lo3];
  assign cmp_local  = cmp_low8 && local_mask_q[cmp_lo3];
  assign cmp_due    = !alu_res[33];
  assign cmp_elig   = !cmp_skip && cmp_due;

  always_comb begin
    if (cmp_paired && cmp_local) begin
      cmp_class = CLASS_PAIRED_LOCAL;
    end else if (cmp_paired) begin
      cmp_class = CLASS_PAIRED;
    end else begin
      cmp_class = CLASS_OTHER;
    end
  end

  // backoff for a failure report
  logic [3:0] new_cnt;
  logic [8:0] delay;

  assign new_cnt = (rd_rec.fail_cnt < FAIL_CAP) ? (rd_rec.fail_cnt + 4'd1) : rd_rec.fail_cnt;
  assign delay   = (new_cnt >= DELAY_LOG) ? DELAY_CAP : (9'd1 << new_cnt);

  logic [CW-1:0] cfg_eff;
  logic          scan_last;

  assign cfg_eff   = (32'(node_count_q) > NODES) ? CW'(NODES) : CW'(node_count_q);
  assign scan_last = ((CW'(scan_q) + CW'(1)) == eff_q);

  // sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    skip_d      = skip_q;
    idx_d       = idx_q;
    ok_d        = ok_q;
    eff_d       = eff_q;
    scan_d      = scan_q;
    cmp_v_d     = cmp_v_q;
    cmp_idx_d   = cmp_idx_q;
    best_d      = best_q;
    found_d     = found_q;
    sel_d       = sel_q;
    act_flag_d  = act_flag_q;
    act_node_d  = act_node_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    s_axis_tready = 1'b0;
    rd_addr     = scan_q;
    mem_we      = 1'b0;
    mem_wdata   = '0;
    alu_op      = ALU_SUB;
    alu_b       = rd_rec.retry;

    // pick the best eligible node as records stream out
    if (cmp_v_q && cmp_elig && (cmp_class < best_q)) begin
      best_d  = cmp_class;
      found_d = 1'b1;
      sel_d   = cmp_lo3;
    end

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          now_d   = in_now;
          skip_d  = in_skip;
          idx_d   = in_idx;
          ok_d    = in_ok;
          eff_d   = cfg_eff;
          scan_d  = '0;
          cmp_v_d = 1'b0;
          best_d  = CLASS_NONE;
          found_d = 1'b0;
          sel_d   = '0;
          if (in_mode == MODE_SELECT) begin
            state_d = (cfg_eff == '0) ? ST_DONE : ST_SCAN;
          end else begin
            state_d = (32'(in_idx) < 32'(cfg_eff)) ? ST_RPT_RD : ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        rd_addr   = scan_q;
        cmp_v_d   = 1'b1;
        cmp_idx_d = scan_q;
        scan_d    = scan_q + IW'(1);
        if (scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmp_v_d = 1'b0;
        state_d = ST_DONE;
      end
      ST_RPT_RD: begin
        rd_addr = IW'(idx_q);
        state_d = ST_RPT_WR;
      end
      ST_RPT_WR: begin
        mem_we = 1'b1;
        alu_op = ALU_ADD;
        alu_b  = RETRY_W'(delay);
        if (ok_q) begin
          mem_wdata  = '0;
          act_flag_d = 1'b1;
          act_node_d = idx_q;
        end else begin
          mem_wdata.fail_cnt = new_cnt;
          mem_wdata.retry    = alu_res[RETRY_W-1:0];
          if (act_flag_q && (act_node_q == idx_q)) begin
            act_flag_d = 1'b0;
          end
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {(act_flag_q ? act_node_q : 3'd0), act_flag_q, sel_q, found_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmp_v_q     <= 1'b0;
      act_flag_q  <= 1'b0;
      act_node_q  <= '0;
      out_valid_q <= 1'b0;
      eff_q       <= '0;
      scan_q      <= '0;
      best_q      <= CLASS_NONE;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_v_q     <= cmp_v_d;
      act_flag_q  <= act_flag_d;
      act_node_q  <= act_node_d;
      out_valid_q <= out_valid_d;
      eff_q       <= eff_d;
      scan_q      <= scan_d;
      best_q      <= best_d;
      found_q     <= found_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    skip_q     <= skip_d;
    idx_q      <= idx_d;
    ok_q       <= ok_d;
    cmp_idx_q  <= cmp_idx_d;
    sel_q      <= sel_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while a request is in flight");

  a_found_matches_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q == (best_q != CLASS_NONE))
    else $error("found flag out of step with best class");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CW'(scan_q) < eff_q))
    else $error("scan ran past the pool");

  a_active_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[4]) |-> (m_axis_tdata[7:5] == 3'd0))
    else $error("active node set without an active node");

  a_sel_zero_unfound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[3:1] == 3'd0))
    else $error("selected index set without a found node");

endmodule
